// ===== rtl/core/swb_pkg.sv =====
// Shared types and constants for the swept box collision pipeline.
// No dependencies; every other file in rtl/core uses this package.
package swb_pkg;

	localparam int NUM_W      = 37;          // numerator magnitude: 22-bit gap, 15 fraction zeros
	localparam int DEN_W      = 16;          // relative velocity magnitude
	localparam int TIME_W     = NUM_W + 1;   // signed full-width time
	localparam int OUT_T_W    = 18;          // reported entry time, Q1.16 signed
	localparam int DIV_STAGES = NUM_W;       // one quotient bit per stage

	localparam logic signed [TIME_W-1:0] ONE_Q16     = TIME_W'(65536);
	localparam logic signed [TIME_W-1:0] NEG_ONE_Q16 = -TIME_W'(65536);

	localparam logic [1:0] NORM_0       = 2'd0;
	localparam logic [1:0] NORM_HALF_PI = 2'd1;
	localparam logic [1:0] NORM_PI      = 2'd2;
	localparam logic [1:0] NORM_3HALF   = 2'd3;

	typedef struct packed {
		logic v_neg;     // relative velocity negative
		logic v_zero;    // relative velocity exactly zero
		logic overlap;   // strict overlap, used when velocity is zero
		logic a_less;    // centre of A below centre of B on this axis
	} axis_side_t;

	typedef struct packed {
		logic       valid;
		axis_side_t x;
		axis_side_t y;
	} side_t;

endpackage

// ===== rtl/core/swb_prep.sv =====
// Input stage: gaps, numerators, velocity magnitudes and per-axis flags.
// Depends on swb_pkg.
module swb_prep (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [19:0]         a_c,
	input  logic signed [19:0]         b_c,
	input  logic        [15:0]         a_w,
	input  logic        [15:0]         b_w,
	input  logic signed [15:0]         a_v,
	input  logic signed [15:0]         b_v,
	output logic                       valid_s1,
	output swb_pkg::axis_side_t        side_s1,
	output logic [swb_pkg::NUM_W-1:0]  num0_s1,
	output logic [swb_pkg::NUM_W-1:0]  num1_s1,
	output logic                       neg0_s1,
	output logic                       neg1_s1,
	output logic [swb_pkg::DEN_W-1:0]  den_s1
);

	logic signed [20:0] dx;
	logic signed [21:0] d2;
	logic        [16:0] sum;
	logic signed [22:0] n0, n1;
	logic        [22:0] m0, m1;
	logic signed [16:0] v;
	logic        [16:0] vm;

	always_comb begin
		dx  = $signed({b_c[19], b_c}) - $signed({a_c[19], a_c});
		d2  = {dx, 1'b0};
		sum = {1'b0, a_w} + {1'b0, b_w};
		n0  = $signed({d2[21], d2}) - $signed({6'b0, sum});
		n1  = $signed({d2[21], d2}) + $signed({6'b0, sum});
		m0  = n0[22] ? 23'(-n0) : 23'(n0);
		m1  = n1[22] ? 23'(-n1) : 23'(n1);
		v   = $signed({a_v[15], a_v}) - $signed({b_v[15], b_v});
		vm  = v[16] ? 17'(-v) : 17'(v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num0_s1         <= {m0[21:0], 15'b0};
			num1_s1         <= {m1[21:0], 15'b0};
			neg0_s1         <= n0[22] ^ v[16];
			neg1_s1         <= n1[22] ^ v[16];
			den_s1          <= vm[15:0];
			side_s1.v_neg   <= v[16];
			side_s1.v_zero  <= (v == 17'sd0);
			// strict overlap: d2 - sum < 0 and d2 + sum > 0
			side_s1.overlap <= n0[22] && !n1[22] && (n1 != 23'sd0);
			side_s1.a_less  <= a_c < b_c;
		end
	end

endmodule

// ===== rtl/core/swb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Depends on swb_pkg.
module swb_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [swb_pkg::NUM_W-1:0]     num,
	input  logic [swb_pkg::DEN_W-1:0]     den,
	input  logic                          neg,
	output logic [swb_pkg::NUM_W-1:0]     quo,
	output logic                          quo_neg
);

	localparam int N = swb_pkg::NUM_W;
	localparam int D = swb_pkg::DEN_W;

	logic [D-1:0] rem_s [0:N];
	logic [N-1:0] num_s [0:N];
	logic [N-1:0] quo_s [0:N];
	logic [D-1:0] den_s [0:N];
	logic         neg_s [0:N];

	assign rem_s[0] = '0;
	assign num_s[0] = num;
	assign quo_s[0] = '0;
	assign den_s[0] = den;
	assign neg_s[0] = neg;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [D:0] trial;
		logic       ge;
		logic [D:0] diff;

		always_comb begin
			trial = {rem_s[k], num_s[k][N-1]};
			diff  = trial - {1'b0, den_s[k]};
			ge    = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[D-1:0] : trial[D-1:0];
				num_s[k+1] <= {num_s[k][N-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][N-2:0], ge};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quo     = quo_s[N];
	assign quo_neg = neg_s[N];

endmodule

// ===== rtl/core/swb_resolve.sv =====
// Back end: signed windows, hit test, later-entry selection, saturation.
// Depends on swb_pkg.
module swb_resolve (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  swb_pkg::side_t                side,
	input  logic [swb_pkg::NUM_W-1:0]     qx0, qx1, qy0, qy1,
	input  logic                          nx0, nx1, ny0, ny1,
	output logic                          valid_s3,
	output logic                          hit_s3,
	output logic signed [swb_pkg::OUT_T_W-1:0] time_s3,
	output logic [1:0]                    code_s3
);

	localparam int TW = swb_pkg::TIME_W;

	function automatic logic signed [TW-1:0] sgn(input logic [TW-2:0] q, input logic n);
		logic signed [TW-1:0] p;
		p = $signed({1'b0, q});
		return n ? -p : p;
	endfunction

	logic signed [TW-1:0] tx0, tx1, ty0, ty1;
	logic signed [TW-1:0] xlo, xhi, ylo, yhi;
	logic signed [TW-1:0] xlo_s2, xhi_s2, ylo_s2, yhi_s2;
	logic                 valid_s2, xless_s2, yless_s2;

	always_comb begin
		tx0 = sgn(qx0, nx0);
		tx1 = sgn(qx1, nx1);
		ty0 = sgn(qy0, ny0);
		ty1 = sgn(qy1, ny1);
		if (side.x.v_zero) begin
			xlo = side.x.overlap ? '0 : swb_pkg::NEG_ONE_Q16;
			xhi = side.x.overlap ? swb_pkg::ONE_Q16 : swb_pkg::NEG_ONE_Q16;
		end else begin
			xlo = side.x.v_neg ? tx1 : tx0;
			xhi = side.x.v_neg ? tx0 : tx1;
		end
		if (side.y.v_zero) begin
			ylo = side.y.overlap ? '0 : swb_pkg::NEG_ONE_Q16;
			yhi = side.y.overlap ? swb_pkg::ONE_Q16 : swb_pkg::NEG_ONE_Q16;
		end else begin
			ylo = side.y.v_neg ? ty1 : ty0;
			yhi = side.y.v_neg ? ty0 : ty1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= side.valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xlo_s2   <= xlo;
			xhi_s2   <= xhi;
			ylo_s2   <= ylo;
			yhi_s2   <= yhi;
			xless_s2 <= side.x.a_less;
			yless_s2 <= side.y.a_less;
		end
	end

	logic                 hit;
	logic                 pick_x;
	logic signed [TW-1:0] t;
	logic signed [swb_pkg::OUT_T_W-1:0] t_sat;
	logic [1:0]           code;

	always_comb begin
		hit = (xlo_s2 <= swb_pkg::ONE_Q16) && (xhi_s2 >= 0) &&
		      (ylo_s2 <= swb_pkg::ONE_Q16) && (yhi_s2 >= 0) &&
		      (xlo_s2 <= yhi_s2) && (ylo_s2 <= xhi_s2);
		pick_x = xlo_s2 > ylo_s2;
		t      = pick_x ? xlo_s2 : ylo_s2;
		if (t > swb_pkg::ONE_Q16) begin
			t_sat = swb_pkg::OUT_T_W'(swb_pkg::ONE_Q16);
		end else if (t < swb_pkg::NEG_ONE_Q16) begin
			t_sat = swb_pkg::OUT_T_W'(swb_pkg::NEG_ONE_Q16);
		end else begin
			t_sat = t[swb_pkg::OUT_T_W-1:0];
		end
		if (pick_x) begin
			code = xless_s2 ? swb_pkg::NORM_PI : swb_pkg::NORM_0;
		end else begin
			code = yless_s2 ? swb_pkg::NORM_3HALF : swb_pkg::NORM_HALF_PI;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3  <= hit;
			time_s3 <= hit ? t_sat : '0;
			code_s3 <= hit ? code : swb_pkg::NORM_0;
		end
	end

endmodule

// ===== rtl/core/swept_box_collision.sv =====
// Top level of the swept box collision pipeline.
// Depends on swb_pkg, swb_prep, swb_div and swb_resolve.
//
// Usage:
//   Slave channel s_*: one beat carries a box pair (centres, sizes,
//   velocities). Master channel m_*: one beat per pair with the hit flag,
//   the entry time (Q1.16, saturated to plus or minus one) and the
//   normal code.
//   Throughput: one beat per cycle while the receiver is not stalling. The
//   pipeline from input beat to output beat is one prep stage, 37 divider
//   stages and two resolve stages; the 37 stages come from the four parallel
//   restoring dividers, one quotient bit per stage each.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken; s_tready is that condition, so a stalled
//   receiver holds every stage in place and nothing is dropped or
//   repeated. A bubble in the output register is filled even under stall.
//   Reset (arst_n low) clears all valid bits; data registers are not
//   cleared. The block is ready as soon as reset is released.
module swept_box_collision (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [19:0] a_center_x, [39:20] a_center_y, [55:40] a_width, [71:56] a_height,
	// [87:72] a_vel_x, [103:88] a_vel_y, [123:104] b_center_x,
	// [143:124] b_center_y, [159:144] b_width, [175:160] b_height,
	// [191:176] b_vel_x, [207:192] b_vel_y
	input  logic [207:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [0] hit, [18:1] entry_time, [20:19] normal_code, [23:21] zero
	output logic [23:0]  m_tdata
);

	localparam int NW = swb_pkg::NUM_W;
	localparam int DW = swb_pkg::DEN_W;

	logic en;

	// advance when the output slot is free or being drained
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic                 vx_s1, vy_s1;
	swb_pkg::axis_side_t  sx_s1, sy_s1;
	logic [NW-1:0]        nx0_s1, nx1_s1, ny0_s1, ny1_s1;
	logic                 gx0_s1, gx1_s1, gy0_s1, gy1_s1;
	logic [DW-1:0]        dx_s1, dy_s1;

	swb_prep u_prep_x (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_tvalid && en),
		.a_c(s_tdata[19:0]), .b_c(s_tdata[123:104]),
		.a_w(s_tdata[55:40]), .b_w(s_tdata[159:144]),
		.a_v(s_tdata[87:72]), .b_v(s_tdata[191:176]),
		.valid_s1(vx_s1), .side_s1(sx_s1),
		.num0_s1(nx0_s1), .num1_s1(nx1_s1),
		.neg0_s1(gx0_s1), .neg1_s1(gx1_s1), .den_s1(dx_s1)
	);

	swb_prep u_prep_y (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_tvalid && en),
		.a_c(s_tdata[39:20]), .b_c(s_tdata[143:124]),
		.a_w(s_tdata[71:56]), .b_w(s_tdata[175:160]),
		.a_v(s_tdata[103:88]), .b_v(s_tdata[207:192]),
		.valid_s1(vy_s1), .side_s1(sy_s1),
		.num0_s1(ny0_s1), .num1_s1(ny1_s1),
		.neg0_s1(gy0_s1), .neg1_s1(gy1_s1), .den_s1(dy_s1)
	);

	// sideband travels beside the dividers, one register per divider stage
	logic                side_vld [0:swb_pkg::DIV_STAGES];
	swb_pkg::axis_side_t side_x   [0:swb_pkg::DIV_STAGES];
	swb_pkg::axis_side_t side_y   [0:swb_pkg::DIV_STAGES];
	swb_pkg::side_t      side_out;

	assign side_vld[0] = vx_s1 && vy_s1;
	assign side_x[0]   = sx_s1;
	assign side_y[0]   = sy_s1;

	for (genvar k = 0; k < swb_pkg::DIV_STAGES; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_vld[k+1] <= 1'b0;
			end else if (en) begin
				side_vld[k+1] <= side_vld[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_x[k+1] <= side_x[k];
				side_y[k+1] <= side_y[k];
			end
		end
	end

	assign side_out = '{valid: side_vld[swb_pkg::DIV_STAGES],
		x: side_x[swb_pkg::DIV_STAGES], y: side_y[swb_pkg::DIV_STAGES]};

	logic [NW-1:0] qx0, qx1, qy0, qy1;
	logic          nx0, nx1, ny0, ny1;

	swb_div u_div_x0 (.clk(clk), .en(en), .num(nx0_s1), .den(dx_s1), .neg(gx0_s1),
		.quo(qx0), .quo_neg(nx0));
	swb_div u_div_x1 (.clk(clk), .en(en), .num(nx1_s1), .den(dx_s1), .neg(gx1_s1),
		.quo(qx1), .quo_neg(nx1));
	swb_div u_div_y0 (.clk(clk), .en(en), .num(ny0_s1), .den(dy_s1), .neg(gy0_s1),
		.quo(qy0), .quo_neg(ny0));
	swb_div u_div_y1 (.clk(clk), .en(en), .num(ny1_s1), .den(dy_s1), .neg(gy1_s1),
		.quo(qy1), .quo_neg(ny1));

	logic                                valid_s3, hit_s3;
	logic signed [swb_pkg::OUT_T_W-1:0]  time_s3;
	logic [1:0]                          code_s3;

	swb_resolve u_resolve (
		.clk(clk), .arst_n(arst_n), .en(en), .side(side_out),
		.qx0(qx0), .qx1(qx1), .qy0(qy0), .qy1(qy1),
		.nx0(nx0), .nx1(nx1), .ny0(ny0), .ny1(ny1),
		.valid_s3(valid_s3), .hit_s3(hit_s3), .time_s3(time_s3), .code_s3(code_s3)
	);

	// the last resolve stage is the output register
	assign m_tvalid = valid_s3;
	assign m_tdata  = {3'b0, code_s3, time_s3, hit_s3};

endmodule
